/* hw/rtl/protobuf_fixed32_field_zeroer_top_defines.svh */
// Assertion macros for the protobuf fixed32 field zeroer.
// Used by protobuf_fixed32_field_zeroer_top; depends on nothing else.
`ifndef PROTOBUF_FIXED32_FIELD_ZEROER_TOP_DEFINES_SVH
`define PROTOBUF_FIXED32_FIELD_ZEROER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, quiet during reset
`define PFZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfz check failed");
// Next-cycle implication, quiet during reset
`define PFZ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfz check failed");
`else
`define PFZ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFZ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/pfz_pkg.sv */
// Shared widths, constants and the result entry type of the fixed32 field zeroer.
// No dependencies; used by the stream interfaces and the top level.
package pfz_pkg;

  localparam int BYTE_W            = 8;
  localparam int VALUE_W           = 32;
  localparam int FIELD_W           = 29;
  localparam int ACCUM_W           = 64;
  localparam int MAX_MESSAGE_BYTES = 65536;
  localparam int SKIP_W            = $clog2(MAX_MESSAGE_BYTES + 1);

  // Result queue: one result waiting plus a burst of four
  localparam int Q_DEPTH = 5;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int BURST   = 4;

  // APB register map
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_TARGET_FIELD = '0;
  localparam logic [FIELD_W-1:0]    TARGET_FIELD_RESET = FIELD_W'(4);

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               out_last;
    logic               found;
    logic [VALUE_W-1:0] saved_bits;
  } result_t;

endpackage

/* hw/rtl/pfz_stream_if.sv */
// Valid/ready stream interfaces for message bytes in and result bytes out.
// Depends on pfz_pkg for field widths.
interface pfz_in_if import pfz_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pfz_out_if import pfz_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic               found;
  logic [VALUE_W-1:0] saved_bits;

  modport source (output valid, output out_byte, output out_last, output found,
                  output saved_bits, input ready);
  modport sink   (input valid, input out_byte, input out_last, input found,
                  input saved_bits, output ready);
endinterface

/* hw/rtl/protobuf_fixed32_field_zeroer_top.sv */
// Protobuf fixed32 field zeroer: one byte per cycle, one APB register (target_field
// at byte address 0, reset 4). Takes a message one byte per transfer, walks the wire
// format and replaces the first fixed32 field numbered target_field by four zero
// bytes; the transfer carrying the final byte reports found and the original value.
// Captured bytes are held until all four arrive, then released as a burst of four;
// a capture cut off by the message end is released unchanged. Each byte is parsed in
// the cycle it is accepted, so one byte per cycle is sustained while the five-entry
// result queue has room: it takes a new byte whenever at most one result is waiting.
`include "protobuf_fixed32_field_zeroer_top_defines.svh"

module protobuf_fixed32_field_zeroer_top import pfz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pfz_in_if.sink                in_ch,
  pfz_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Walk modes
  localparam logic [2:0] MODE_TAG   = 3'd0;
  localparam logic [2:0] MODE_VALUE = 3'd1;
  localparam logic [2:0] MODE_LEN   = 3'd2;
  localparam logic [2:0] MODE_SKIP  = 3'd3;
  localparam logic [2:0] MODE_HOLD  = 3'd4;
  localparam logic [2:0] MODE_DONE  = 3'd5;

  // Wire types
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_I64    = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_I32    = 3'd5;

  localparam logic [3:0] VARINT_LAST_BYTE = 4'd9;

  logic [FIELD_W-1:0] target_r;

  logic [2:0]         mode_r,   mode_nxt;
  logic [ACCUM_W-1:0] accum_r,  accum_nxt;
  logic [3:0]         shift_r,  shift_nxt;
  logic [SKIP_W-1:0]  skip_r,   skip_nxt;
  logic [VALUE_W-1:0] held_r,   held_nxt;
  logic [2:0]         hcnt_r,   hcnt_nxt;
  logic               found_r,  found_nxt;

  result_t            q_r [Q_DEPTH];
  result_t            q_nxt [Q_DEPTH];
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  result_t            ent [BURST];
  logic [2:0]         push_cnt;

  logic               in_acc, out_acc;
  logic [BYTE_W-1:0]  b;
  logic               last;
  logic [6:0]         vshamt;
  logic [ACCUM_W-1:0] acc_upd;
  logic               v_done, v_ovf;
  logic [3:0]         v_shift;
  logic [VALUE_W-1:0] field;
  logic [SKIP_W-1:0]  skip_dec;
  logic [1:0]         hpos;
  logic [VALUE_W-1:0] held_cap;
  logic [Q_CNT_W-1:0] base;
  logic [Q_CNT_W-1:0] slot;

  // APB register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TARGET_FIELD) ? APB_DATA_W'(target_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_FIELD_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TARGET_FIELD) begin
      target_r <= pwdata[FIELD_W-1:0];
    end
  end

  // Handshakes
  assign in_ch.ready  = (cnt_r <= Q_CNT_W'(1));
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (cnt_r != '0);
  assign out_acc      = out_ch.valid && out_ch.ready;

  assign out_ch.out_byte   = q_r[0].out_byte;
  assign out_ch.out_last   = q_r[0].out_last;
  assign out_ch.found      = q_r[0].found;
  assign out_ch.saved_bits = q_r[0].saved_bits;

  assign b    = in_ch.in_byte;
  assign last = in_ch.in_last;

  // Varint byte: merge seven bits at the current group position
  assign vshamt   = 7'(shift_r) * 7'd7;
  assign acc_upd  = accum_r | (ACCUM_W'(b[6:0]) << vshamt);
  assign v_done   = !b[7];
  assign v_ovf    = b[7] && (shift_r == VARINT_LAST_BYTE);
  assign v_shift  = (v_done || v_ovf) ? 4'd0 : shift_r + 4'd1;
  assign field    = acc_upd[VALUE_W+2:3];
  assign skip_dec = (skip_r != '0) ? skip_r - SKIP_W'(1) : skip_r;

  // Captured field bytes, current byte included
  assign hpos     = hcnt_r[1:0];
  assign held_cap = held_r | (VALUE_W'(b) << {hpos, 3'b000});

  // Parse one byte and build its results
  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    shift_nxt = shift_r;
    skip_nxt  = skip_r;
    held_nxt  = held_r;
    hcnt_nxt  = hcnt_r;
    found_nxt = found_r;
    push_cnt  = 3'd1;
    for (int i = 0; i < BURST; i++) begin
      ent[i] = '0;
    end
    ent[0].out_byte   = b;
    ent[0].out_last   = last;
    ent[0].found      = last && found_r;
    ent[0].saved_bits = (last && found_r) ? held_r : '0;

    case (mode_r)
      MODE_TAG: begin
        accum_nxt = acc_upd;
        shift_nxt = v_shift;
        if (v_ovf) begin
          mode_nxt = MODE_DONE;
        end else if (v_done) begin
          accum_nxt = '0;
          case (acc_upd[2:0])
            WIRE_VARINT: mode_nxt = MODE_VALUE;
            WIRE_I64: begin
              skip_nxt = SKIP_W'(8);
              mode_nxt = MODE_SKIP;
            end
            WIRE_LEN: mode_nxt = MODE_LEN;
            WIRE_I32: begin
              if (field == VALUE_W'(target_r)) begin
                mode_nxt = MODE_HOLD;
                held_nxt = '0;
                hcnt_nxt = '0;
              end else begin
                skip_nxt = SKIP_W'(4);
                mode_nxt = MODE_SKIP;
              end
            end
            default: mode_nxt = MODE_DONE;
          endcase
        end
      end
      MODE_VALUE: begin
        accum_nxt = acc_upd;
        shift_nxt = v_shift;
        if (v_ovf) begin
          mode_nxt = MODE_DONE;
        end else if (v_done) begin
          accum_nxt = '0;
          mode_nxt  = MODE_TAG;
        end
      end
      MODE_LEN: begin
        accum_nxt = acc_upd;
        shift_nxt = v_shift;
        if (v_ovf) begin
          mode_nxt = MODE_DONE;
        end else if (v_done) begin
          accum_nxt = '0;
          if (acc_upd > ACCUM_W'(MAX_MESSAGE_BYTES)) begin
            mode_nxt = MODE_DONE;
          end else if (acc_upd == '0) begin
            mode_nxt = MODE_TAG;
          end else begin
            skip_nxt = acc_upd[SKIP_W-1:0];
            mode_nxt = MODE_SKIP;
          end
        end
      end
      MODE_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          mode_nxt = MODE_TAG;
        end
      end
      MODE_HOLD: begin
        held_nxt = held_cap;
        hcnt_nxt = {1'b0, hpos} + 3'd1;
        if (hpos == 2'd3) begin
          // Full capture: release four zero bytes
          found_nxt = 1'b1;
          mode_nxt  = MODE_DONE;
          push_cnt  = 3'(BURST);
          for (int i = 0; i < BURST; i++) begin
            ent[i].out_byte   = '0;
            ent[i].out_last   = last && (i == BURST - 1);
            ent[i].found      = last && (i == BURST - 1);
            ent[i].saved_bits = (last && (i == BURST - 1)) ? held_cap : '0;
          end
        end else if (last) begin
          // Capture cut off by the end: release the original bytes
          push_cnt = {1'b0, hpos} + 3'd1;
          for (int i = 0; i < BURST; i++) begin
            ent[i].out_byte   = held_cap[i*BYTE_W +: BYTE_W];
            ent[i].out_last   = (2'(i) == hpos);
            ent[i].found      = 1'b0;
            ent[i].saved_bits = '0;
          end
        end else begin
          push_cnt = 3'd0;
        end
      end
      default: begin
        mode_nxt = MODE_DONE;
      end
    endcase

    // Message end: back to the start state
    if (last) begin
      mode_nxt  = MODE_TAG;
      accum_nxt = '0;
      shift_nxt = '0;
      skip_nxt  = '0;
      held_nxt  = '0;
      hcnt_nxt  = '0;
      found_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TAG;
      accum_r <= '0;
      shift_r <= '0;
      skip_r  <= '0;
      held_r  <= '0;
      hcnt_r  <= '0;
      found_r <= 1'b0;
    end else if (in_acc) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      shift_r <= shift_nxt;
      skip_r  <= skip_nxt;
      held_r  <= held_nxt;
      hcnt_r  <= hcnt_nxt;
      found_r <= found_nxt;
    end
  end

  // Result queue: drop the head on a transfer, append this byte's results
  assign base = cnt_r - Q_CNT_W'(out_acc);

  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      slot = Q_CNT_W'(i) - base;
      if (Q_CNT_W'(i) < base) begin
        q_nxt[i] = out_acc ? q_r[(i + 1 < Q_DEPTH) ? i + 1 : i] : q_r[i];
      end else if (in_acc && (slot < Q_CNT_W'(push_cnt))) begin
        q_nxt[i] = ent[slot[1:0]];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    cnt_nxt = base + (in_acc ? Q_CNT_W'(push_cnt) : Q_CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Checks
  `PFZ_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, cnt_r <= Q_CNT_W'(Q_DEPTH))
  `PFZ_ASSERT_IMP(a_found_on_last, clk, rst_n, out_ch.valid && out_ch.found, out_ch.out_last)
  `PFZ_ASSERT_IMP(a_hold_short, clk, rst_n, mode_r == MODE_HOLD, hcnt_r < 3'd4)
  `PFZ_ASSERT_NXT(a_msg_restart, clk, rst_n, in_acc && in_ch.in_last,
                  mode_r == MODE_TAG && !found_r && hcnt_r == 3'd0)

endmodule
